// ===== rtl/core/eo3d_pkg.sv =====
`default_nettype none

package eo3d_pkg;

  // field widths of the stream payloads
  localparam int unsigned IN_FIELD_W   = 20;
  localparam int unsigned IN_FIELDS    = 12;
  localparam int unsigned IN_TDATA_W   = 240;
  localparam int unsigned DET_W        = 64;
  localparam int unsigned SIGN_W       = 2;
  localparam int unsigned OUT_TDATA_W  = 72;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - DET_W - SIGN_W;

  localparam int unsigned COORD_BITS_DEF = 20;

  // sign codes, two's complement
  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

endpackage

`default_nettype wire

// ===== rtl/core/exact_orient3d_determinant.sv =====
`default_nettype none

// channel   dir  fields (low bit first)
// s_axis    in   tdata: row0_x row0_y row0_z row1_x ... row3_z, 20 bits each
// m_axis    out  tdata: det_value[63:0], det_sign[65:64], zero pad to 72 bits
//
// six register stages: z differences, y*dz products, 3x3 cofactors,
// x*cofactor products, signed sum, output register with sign.
// one transaction per clock while m_axis is not stalled.
// all stages advance together; a stall on m_axis holds the whole pipeline
// and drops s_axis_tready in the same cycle.
// reset clears the valid bits only.

module exact_orient3d_determinant #(
  parameter int unsigned COORD_BITS = eo3d_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  // row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
  // row2_x, row2_y, row2_z, row3_x, row3_y, row3_z
  input  wire logic [eo3d_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // det_value[63:0], det_sign[65:64], zeros above
  output      logic [eo3d_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned DW   = CW + 1;        // coordinate difference
  localparam int unsigned PW   = CW + DW;       // y * dz
  localparam int unsigned CFW  = PW + 2;        // cofactor
  localparam int unsigned XW   = CW + CFW;      // x * cofactor
  localparam int unsigned SW   = XW + 2;        // four-term sum
  localparam int unsigned EW   = (SW > eo3d_pkg::DET_W) ? SW : eo3d_pkg::DET_W;
  localparam int unsigned NSTG = 6;
  localparam int unsigned FW   = eo3d_pkg::IN_FIELD_W;

  // z difference pairs: 01 02 03 12 13 23
  localparam int unsigned ZA[6] = '{0, 0, 0, 1, 1, 2};
  localparam int unsigned ZB[6] = '{1, 2, 3, 2, 3, 3};
  // cofactor k over the rows other than k: y_a*dz_bc - y_b*dz_ac + y_c*dz_ab
  localparam int unsigned YSEL[4][3]  = '{'{1, 2, 3}, '{0, 2, 3}, '{0, 1, 3}, '{0, 1, 2}};
  localparam int unsigned DZSEL[4][3] = '{'{5, 4, 3}, '{5, 2, 1}, '{4, 2, 0}, '{3, 1, 0}};

  logic                  en;
  logic [NSTG-1:0]       v_q, v_d;

  logic signed [CW-1:0]  x_in[4], y_in[4], z_in[4];
  logic signed [CW-1:0]  x1_q[4], x1_d[4], y1_q[4], y1_d[4];
  logic signed [DW-1:0]  dz1_q[6], dz1_d[6];
  logic signed [CW-1:0]  x2_q[4], x3_q[4];
  logic signed [PW-1:0]  pr2_q[12], pr2_d[12];
  logic signed [CFW-1:0] cf3_q[4], cf3_d[4];
  logic signed [XW-1:0]  xp4_q[4], xp4_d[4];
  logic signed [SW-1:0]  sum5_q, sum5_d;
  logic signed [EW-1:0]  sum_ext;
  logic [eo3d_pkg::DET_W-1:0]  det_q, det_d;
  logic [eo3d_pkg::SIGN_W-1:0] sgn_q, sgn_d;

  assign en            = !v_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[NSTG-1];
  assign m_axis_tdata  = {{eo3d_pkg::OUT_PAD_W{1'b0}}, sgn_q, det_q};
  assign v_d           = {v_q[NSTG-2:0], s_axis_tvalid};

  // only the low COORD_BITS of each field count, sign-extended
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      x_in[r] = s_axis_tdata[(3*r)*FW +: CW];
      y_in[r] = s_axis_tdata[(3*r+1)*FW +: CW];
      z_in[r] = s_axis_tdata[(3*r+2)*FW +: CW];
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      x1_d[r] = x_in[r];
      y1_d[r] = y_in[r];
    end
    for (int p = 0; p < 6; p++) begin
      dz1_d[p] = DW'(z_in[ZA[p]]) - DW'(z_in[ZB[p]]);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int t = 0; t < 3; t++) begin
        pr2_d[3*k+t] = PW'(y1_q[YSEL[k][t]]) * PW'(dz1_q[DZSEL[k][t]]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cf3_d[k] = CFW'(pr2_q[3*k]) - CFW'(pr2_q[3*k+1]) + CFW'(pr2_q[3*k+2]);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xp4_d[k] = XW'(x3_q[k]) * XW'(cf3_q[k]);
    end
  end

  assign sum5_d = SW'(xp4_q[0]) - SW'(xp4_q[1]) + SW'(xp4_q[2]) - SW'(xp4_q[3]);

  // result is taken modulo 2^64
  assign sum_ext = EW'(sum5_q);
  assign det_d   = sum_ext[eo3d_pkg::DET_W-1:0];

  always_comb begin
    if (det_d[eo3d_pkg::DET_W-1]) begin
      sgn_d = eo3d_pkg::SIGN_NEG;
    end else if (det_d != '0) begin
      sgn_d = eo3d_pkg::SIGN_POS;
    end else begin
      sgn_d = eo3d_pkg::SIGN_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q   <= x1_d;
      y1_q   <= y1_d;
      dz1_q  <= dz1_d;
      x2_q   <= x1_q;
      pr2_q  <= pr2_d;
      x3_q   <= x2_q;
      cf3_q  <= cf3_d;
      xp4_q  <= xp4_d;
      sum5_q <= sum5_d;
      det_q  <= det_d;
      sgn_q  <= sgn_d;
    end
  end

  a_neg_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((sgn_q == eo3d_pkg::SIGN_NEG) == det_q[eo3d_pkg::DET_W-1]))
    else $error("sign code disagrees with determinant msb");

  a_zero_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((sgn_q == eo3d_pkg::SIGN_ZERO) == (det_q == '0)))
    else $error("zero sign code disagrees with determinant value");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline moved during a stall");

  a_reach_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v_q[NSTG-2]) |=> m_axis_tvalid)
    else $error("transaction lost before output register");

endmodule

`default_nettype wire
